[sv/c3f_pkg.sv]
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared types and constants for the 3x3 image filter core.
// ----------------------------------------------------------------------------
package c3f_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 20;
   localparam int LAP_W    = 21;
   localparam int RECIP_K  = 20;
   localparam int RECIP_W  = 21;
   localparam int PROD_W   = SUM_W + RECIP_W;

   localparam logic [1:0] MODE_BLUR    = 2'd0;
   localparam logic [1:0] MODE_LAPLACE = 2'd1;
   localparam logic [1:0] MODE_SHARPEN = 2'd2;

   localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;
   localparam logic [1:0] REG_MAX_VALUE    = 2'd3;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] in_red;
      logic [15:0] in_green;
      logic [15:0] in_blue;
   } req_data_type;

   typedef struct packed {
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
      logic        frame_end;
   } rsp_data_type;

   typedef struct packed {
      logic        start;
      logic [1:0]  mode;
      logic        ok_r0;
      logic        ok_r2;
      logic        ok_c0;
      logic        ok_c2;
      logic [15:0] max_value;
   } lane_ctrl_type;

   // floor(2^RECIP_K / n) for the neighbour counts that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd1:    r = 21'd1048576;
         4'd2:    r = 21'd524288;
         4'd3:    r = 21'd349525;
         4'd4:    r = 21'd262144;
         4'd6:    r = 21'd174762;
         4'd9:    r = 21'd116508;
         default: r = 21'd1048576;
      endcase
      return r;
   endfunction

endpackage

[sv/c3f_ram.sv]
// ----------------------------------------------------------------------------
// c3f_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module c3f_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/c3f_lane.sv]
// ----------------------------------------------------------------------------
// c3f_lane
// One channel of the filter: four-stage pipeline from window to clamped sample.
// ----------------------------------------------------------------------------
module c3f_lane import c3f_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctrl_type            ctrl,
   input  logic [8:0][SAMPLE_W-1:0] win,
   output logic [SAMPLE_W-1:0]      result,
   output logic                     done
);

   logic [SUM_W-1:0]        sum_a_in, sum_a_ff;
   logic [3:0]              n_a_in, n_a_ff;
   logic signed [LAP_W-1:0] lap_a_in, lap_a_ff;
   logic                    blur_a_ff, v_a_ff;
   logic [15:0]             maxv_a_ff;

   logic [PROD_W-1:0]       prod_b_ff;
   logic [SUM_W-1:0]        sum_b_ff;
   logic [3:0]              n_b_ff;
   logic signed [LAP_W-1:0] lap_b_ff;
   logic                    blur_b_ff, v_b_ff;
   logic [15:0]             maxv_b_ff;

   logic [SUM_W-1:0]        q_c_in, q_c_ff;
   logic signed [LAP_W-1:0] lap_c_ff;
   logic                    blur_c_ff, v_c_ff;
   logic [15:0]             maxv_c_ff;

   logic [SAMPLE_W-1:0]     result_in, result_ff;
   logic                    done_ff;

   logic [2:0] ok_r, ok_c;
   logic [1:0] nr, nc;
   logic [SUM_W-1:0]  q_est, rem;
   logic [SUM_W+3:0]  qn;
   logic signed [LAP_W-1:0] val;

   always_comb begin
      ok_r = {ctrl.ok_r2, 1'b1, ctrl.ok_r0};
      ok_c = {ctrl.ok_c2, 1'b1, ctrl.ok_c0};
      sum_a_in = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (ok_r[r] && ok_c[c]) begin
               sum_a_in = sum_a_in + SUM_W'(win[r*3+c]);
            end
         end
      end
      nr = 2'd1 + 2'(ctrl.ok_r0) + 2'(ctrl.ok_r2);
      nc = 2'd1 + 2'(ctrl.ok_c0) + 2'(ctrl.ok_c2);
      n_a_in = 4'(nr) * 4'(nc);
      lap_a_in = $signed(LAP_W'({win[4], 2'b00}));
      if (ctrl.mode == MODE_SHARPEN) begin
         lap_a_in = lap_a_in + $signed(LAP_W'(win[4]));
      end
      if (ctrl.ok_r0) lap_a_in = lap_a_in - $signed(LAP_W'(win[1]));
      if (ctrl.ok_r2) lap_a_in = lap_a_in - $signed(LAP_W'(win[7]));
      if (ctrl.ok_c0) lap_a_in = lap_a_in - $signed(LAP_W'(win[3]));
      if (ctrl.ok_c2) lap_a_in = lap_a_in - $signed(LAP_W'(win[5]));
   end

   always_comb begin
      q_est = prod_b_ff[PROD_W-2 -: SUM_W];
      qn    = (SUM_W+4)'(q_est) * (SUM_W+4)'(n_b_ff);
      rem   = sum_b_ff - SUM_W'(qn);
      q_c_in = (rem >= SUM_W'(n_b_ff)) ? q_est + 1'b1 : q_est;
   end

   always_comb begin
      val = blur_c_ff ? $signed({1'b0, q_c_ff}) : lap_c_ff;
      if (val < 0) begin
         result_in = '0;
      end else if (val > $signed(LAP_W'(maxv_c_ff))) begin
         result_in = maxv_c_ff;
      end else begin
         result_in = SAMPLE_W'(val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff  <= 1'b0;
         v_b_ff  <= 1'b0;
         v_c_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v_a_ff  <= ctrl.start;
         v_b_ff  <= v_a_ff;
         v_c_ff  <= v_b_ff;
         done_ff <= v_c_ff;
      end
      if (ctrl.start) begin
         sum_a_ff  <= sum_a_in;
         n_a_ff    <= n_a_in;
         lap_a_ff  <= lap_a_in;
         blur_a_ff <= (ctrl.mode != MODE_LAPLACE) && (ctrl.mode != MODE_SHARPEN);
         maxv_a_ff <= ctrl.max_value;
      end
      if (v_a_ff) begin
         prod_b_ff <= PROD_W'(sum_a_ff) * PROD_W'(recip(n_a_ff));
         sum_b_ff  <= sum_a_ff;
         n_b_ff    <= n_a_ff;
         lap_b_ff  <= lap_a_ff;
         blur_b_ff <= blur_a_ff;
         maxv_b_ff <= maxv_a_ff;
      end
      if (v_b_ff) begin
         q_c_ff    <= q_c_in;
         lap_c_ff  <= lap_b_ff;
         blur_c_ff <= blur_b_ff;
         maxv_c_ff <= maxv_b_ff;
      end
      if (v_c_ff) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
   assign done   = done_ff;

endmodule

[sv/conv3x3_image_filter_core.sv]
// ----------------------------------------------------------------------------
// conv3x3_image_filter_core
// 3x3 blur / Laplace / sharpen over a raster pixel stream, one lane per channel.
//
//   channel  ports                      handshake
//   req      req_valid/stall/data       accepted on valid && !stall
//   rsp      rsp_valid/stall/data       taken on valid && !stall
//   csr      csr_valid/ready/index/data written on valid && ready
//
// A pixel that yields a result goes through accept, line-store read and write,
// four lane stages, lane done and output load. One with no result returns to
// idle after the line-store write; a dropped drain item is only accepted.
// Reset is synchronous; line stores are not cleared. req_stall is high while
// a request is in work; rsp_stall holds the result register.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_core import c3f_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int CHANNELS  = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int LW = SAMPLE_W * CHANNELS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRITE = 3'd1;
   localparam logic [2:0] ST_CALC  = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [15:0] maxv_ff;

   logic [AW-1:0] in_col_ff, col_ff, col_eff;
   logic [16:0]   in_row_ff;
   logic [AW-1:0] out_col_ff;
   logic [15:0]   out_row_ff;
   logic [LW-1:0] pix_ff;
   logic          fe_ff;
   logic [8:0][LW-1:0] win_ff;
   lane_ctrl_type ctrl_ff;
   logic          rsp_valid_ff;
   rsp_data_type  rsp_data_ff;

   logic [WW-1:0] eff_w;
   logic [15:0]   eff_h;
   logic          draining, accept, drop, emit, frame_end;
   logic [LW-1:0] tap0, tap1, pix_in;
   logic [AW-1:0] col_next;
   logic          col_wrap;
   logic [2:0][SAMPLE_W-1:0] lane_res;
   logic [CHANNELS-1:0]      lane_done;
   logic          clear_cnt;

   always_comb begin
      if (width_ff == 11'd0) begin
         eff_w = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      eff_h     = (height_ff == 16'd0) ? 16'd1 : height_ff;
      draining  = in_row_ff >= {1'b0, eff_h};
      accept    = req_valid && !req_stall;
      drop      = (req_data.kind == KIND_DRAIN) && !draining;
      col_eff   = (32'(in_col_ff) >= 32'(eff_w)) ? '0 : in_col_ff;
      pix_in    = draining ? '0
                  : LW'({req_data.in_blue, req_data.in_green, req_data.in_red});
      emit      = (in_row_ff >= 17'd2) || (in_row_ff == 17'd1 && col_ff != '0);
      col_wrap  = (32'(col_ff) + 1) >= 32'(eff_w);
      col_next  = col_wrap ? '0 : AW'(32'(col_ff) + 1);
      frame_end = ((17'(out_row_ff) + 17'd1) >= 17'(eff_h))
                  && ((32'(out_col_ff) + 1) >= 32'(eff_w));
      clear_cnt = csr_valid && csr_ready
                  && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);
   end

   c3f_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (col_ff),
      .wr_data (pix_ff),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (tap0)
   );

   c3f_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (col_ff),
      .wr_data (tap0),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (tap1)
   );

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         if (g < CHANNELS) begin : g_on
            logic [8:0][SAMPLE_W-1:0] lane_win;
            always_comb begin
               for (int k = 0; k < 9; k++) begin
                  lane_win[k] = win_ff[k][g*SAMPLE_W +: SAMPLE_W];
               end
            end
            c3f_lane u_lane (
               .clock  (clock),
               .reset  (reset),
               .ctrl   (ctrl_ff),
               .win    (lane_win),
               .result (lane_res[g]),
               .done   (lane_done[g])
            );
         end else begin : g_off
            assign lane_res[g] = '0;
         end
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && !drop) state_in = ST_WRITE;
         ST_WRITE: state_in = emit ? ST_CALC : ST_IDLE;
         ST_CALC:  if (&lane_done) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_BLUR;
         width_ff     <= 11'd640;
         height_ff    <= 16'd480;
         maxv_ff      <= 16'd255;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         win_ff       <= '0;
         ctrl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ctrl_ff.start <= 1'b0;
         if (state_ff == ST_WRITE) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r*3]   <= win_ff[r*3+1];
               win_ff[r*3+1] <= win_ff[r*3+2];
            end
            win_ff[2] <= tap1;
            win_ff[5] <= tap0;
            win_ff[8] <= pix_ff;
            in_col_ff <= col_next;
            if (col_wrap) in_row_ff <= in_row_ff + 17'd1;
            if (emit) begin
               ctrl_ff.start     <= 1'b1;
               ctrl_ff.mode      <= mode_ff;
               ctrl_ff.max_value <= maxv_ff;
               ctrl_ff.ok_r0     <= out_row_ff != 16'd0;
               ctrl_ff.ok_r2     <= (17'(out_row_ff) + 17'd1) < 17'(eff_h);
               ctrl_ff.ok_c0     <= out_col_ff != '0;
               ctrl_ff.ok_c2     <= (32'(out_col_ff) + 1) < 32'(eff_w);
               if (frame_end) begin
                  in_col_ff  <= '0;
                  in_row_ff  <= '0;
                  out_col_ff <= '0;
                  out_row_ff <= '0;
               end else if ((32'(out_col_ff) + 1) >= 32'(eff_w)) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 16'd1;
               end else begin
                  out_col_ff <= out_col_ff + 1'b1;
               end
            end
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_FILTER_MODE:  mode_ff   <= csr_data[1:0];
               REG_FRAME_WIDTH:  width_ff  <= csr_data[10:0];
               REG_FRAME_HEIGHT: height_ff <= csr_data;
               REG_MAX_VALUE:    maxv_ff   <= csr_data;
               default: ;
            endcase
         end
         if (clear_cnt) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= pix_in;
         col_ff <= col_eff;
      end
      if (state_ff == ST_WRITE) begin
         fe_ff <= frame_end;
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.out_red   <= lane_res[0];
         rsp_data_ff.out_green <= lane_res[1];
         rsp_data_ff.out_blue  <= lane_res[2];
         rsp_data_ff.frame_end <= fe_ff;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/conv3x3_image_filter_core_test.sv]
// ----------------------------------------------------------------------------
// conv3x3_image_filter_core_test
// Streams small frames through the 3x3 filter core in every mode and checks
// each filtered pixel against a behavioral window predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3x3_image_filter_core_test;
   import c3f_pkg::*;

   localparam int MAXW = 1024;

   class filter_scoreboard;
      rsp_data_type pending[$];
      logic [47:0]  row_a[MAXW];
      logic [47:0]  row_b[MAXW];
      logic [47:0]  win[9];
      int unsigned  mode, width, height, maxv;
      int unsigned  icol, irow, ocol, orow;
      int           errors;

      function void clear_pos();
         icol = 0; irow = 0; ocol = 0; orow = 0;
      endfunction

      function void init();
         mode = MODE_BLUR; width = 640; height = 480; maxv = 255;
         foreach (win[i]) win[i] = '0;
         foreach (row_a[i]) begin
            row_a[i] = '0;
            row_b[i] = '0;
         end
         clear_pos();
         errors = 0;
         pending.delete();
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] v);
         case (idx)
            REG_FILTER_MODE:  mode = v[1:0];
            REG_FRAME_WIDTH:  begin width = v[10:0]; clear_pos(); end
            REG_FRAME_HEIGHT: begin height = v; clear_pos(); end
            REG_MAX_VALUE:    maxv = v;
         endcase
      endfunction

      function int unsigned eff_w();
         if (width == 0) return 1;
         return (width > MAXW) ? MAXW : width;
      endfunction

      function logic [15:0] filt(int ch, int unsigned w, int unsigned h);
         bit okr[3], okc[3];
         int res, sum, n;
         okr[0] = orow >= 1; okr[1] = 1; okr[2] = orow + 1 < h;
         okc[0] = ocol >= 1; okc[1] = 1; okc[2] = ocol + 1 < w;
         if (mode == MODE_LAPLACE || mode == MODE_SHARPEN) begin
            res = int'(win[4][16*ch +: 16]) * ((mode == MODE_LAPLACE) ? 4 : 5);
            if (okr[0]) res -= win[1][16*ch +: 16];
            if (okr[2]) res -= win[7][16*ch +: 16];
            if (okc[0]) res -= win[3][16*ch +: 16];
            if (okc[2]) res -= win[5][16*ch +: 16];
         end else begin
            sum = 0; n = 0;
            for (int r = 0; r < 3; r++)
               for (int c = 0; c < 3; c++)
                  if (okr[r] && okc[c]) begin
                     sum += win[r*3+c][16*ch +: 16];
                     n++;
                  end
            res = sum / n;
         end
         if (res < 0) res = 0;
         if (res > int'(maxv)) res = maxv;
         return res[15:0];
      endfunction

      function void note_request(req_data_type d);
         int unsigned w, h;
         logic [47:0] p, t0, t1;
         bit drain, emit;
         rsp_data_type e;
         w = eff_w();
         h = (height == 0) ? 1 : height;
         drain = irow >= h;
         if (d.kind == KIND_DRAIN && !drain) return;
         if (icol >= w) icol = 0;
         p = drain ? '0 : {d.in_blue, d.in_green, d.in_red};
         t1 = row_b[icol];
         t0 = row_a[icol];
         row_b[icol] = t0;
         row_a[icol] = p;
         for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
         end
         win[2] = t1; win[5] = t0; win[8] = p;
         emit = irow >= 2 || (irow == 1 && icol >= 1);
         icol++;
         if (icol >= w) begin
            icol = 0;
            irow++;
         end
         if (!emit) return;
         e.out_red = filt(0, w, h);
         e.out_green = filt(1, w, h);
         e.out_blue = filt(2, w, h);
         if (orow + 1 >= h && ocol + 1 >= w) begin
            e.frame_end = 1;
            clear_pos();
         end else begin
            e.frame_end = 0;
            ocol++;
            if (ocol >= w) begin
               ocol = 0;
               orow++;
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_data_type a);
         rsp_data_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", a);
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", e, a);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic req_stall, rsp_valid, csr_ready;
   req_data_type req_data = '0;
   rsp_data_type rsp_data;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   filter_scoreboard sb;
   bit quiet = 0;
   int idle_cycles = 0;

   conv3x3_image_filter_core DUT (.*);

   initial forever #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= reset ? 1'b0 : (!quiet && $urandom_range(99) < 15);

   task automatic write_reg(logic [1:0] idx, logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send(logic kind, logic [15:0] r, logic [15:0] g, logic [15:0] b);
      req_data_type d;
      d.kind = kind; d.in_red = r; d.in_green = g; d.in_blue = b;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_data <= d;
      do @(posedge clock); while (req_stall);
      sb.note_request(d);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic settle();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] rnd_sample(int unsigned maxv);
      case ($urandom_range(3))
         0: return 16'd0;
         1: return 16'(maxv);
         2: return 16'($urandom);
         default: return 16'($urandom_range(maxv));
      endcase
   endfunction

   // one frame of w*h pixels then w+1 drains, with occasional noise items
   task automatic run_frame(int unsigned w, int unsigned h, int unsigned maxv,
                            bit noisy);
      for (int i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(19) == 0) send(KIND_DRAIN, 16'($urandom), 0, 0);
         send(KIND_PIXEL, rnd_sample(maxv), rnd_sample(maxv), rnd_sample(maxv));
      end
      for (int i = 0; i <= w; i++)
         send((noisy && $urandom_range(3) == 0) ? KIND_PIXEL : KIND_DRAIN,
              16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int unsigned w, h, m;
      sb = new();
      sb.init();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: small frames, extreme values, blur and mode 3, odd register values
      write_reg(REG_FRAME_WIDTH, 3);
      write_reg(REG_FRAME_HEIGHT, 2);
      write_reg(REG_MAX_VALUE, 16'hffff);
      write_reg(REG_FILTER_MODE, 16'(MODE_BLUR));
      send(KIND_DRAIN, 16'hffff, 16'hffff, 16'hffff);
      send(KIND_PIXEL, 16'hffff, 0, 16'hffff);
      send(KIND_PIXEL, 0, 16'hffff, 16'h8000);
      send(KIND_PIXEL, 16'hffff, 16'hffff, 0);
      send(KIND_PIXEL, 16'h1234, 0, 16'hffff);
      send(KIND_PIXEL, 0, 16'hffff, 16'h0001);
      send(KIND_PIXEL, 16'hffff, 16'h5555, 16'haaaa);
      repeat (4) send(KIND_PIXEL, 16'hffff, 16'hffff, 16'hffff);
      settle();
      write_reg(REG_FILTER_MODE, 3);
      write_reg(REG_FRAME_WIDTH, 0);
      write_reg(REG_FRAME_HEIGHT, 0);
      run_frame(1, 1, 16'hffff, 0);
      settle();

      quiet = 1;
      for (int f = 0; f < 50; f++) begin
         if (f == 8) quiet = 0;
         write_reg(REG_FILTER_MODE, 16'($urandom_range(3)));
         m = ($urandom_range(4) == 0) ? 1 : (($urandom_range(1)) ? 16'hffff : $urandom_range(1, 65535));
         write_reg(REG_MAX_VALUE, 16'(m));
         if (f == 20) begin
            // width above MAX_WIDTH: a short run inside the first row
            write_reg(REG_FRAME_WIDTH, 16'd2047);
            write_reg(REG_FRAME_HEIGHT, 16'd2);
            repeat (40) send(KIND_PIXEL, rnd_sample(m), rnd_sample(m), rnd_sample(m));
            settle();
            continue;
         end
         w = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 5);
         h = $urandom_range(1, 4);
         write_reg(REG_FRAME_WIDTH, 16'(w));
         write_reg(REG_FRAME_HEIGHT, 16'(h));
         run_frame(w, h, m, f % 3 == 0);
         settle();
      end
      write_reg(REG_FRAME_HEIGHT, 16'hffff);
      write_reg(REG_FRAME_WIDTH, 16'h0400);
      settle();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
